// ----- rtl/cdrc_pkg.sv -----
// ============================================================================
// cdrc_pkg
// Shared types, widths and constants of the clock drift ratio controller.
// ============================================================================
package cdrc_pkg;

    localparam int TIME_BITS       = 48;
    localparam int FILL_BITS       = 24;
    localparam int ERROR_FRAC_BITS = 16;

    localparam int FE_W     = FILL_BITS + ERROR_FRAC_BITS + 8;
    localparam int MAG_W    = FE_W + 1;
    localparam int SR_W     = 18;
    localparam int CH_W     = 4;
    localparam int GAIN_W   = 16;
    localparam int TAU_W    = 16;
    localparam int LIM_W    = 17;
    localparam int DT_W     = 16;
    localparam int RATIO_W  = 28;
    localparam int PPB_W    = 30;
    localparam int K_W      = 10;
    localparam int CAP_W    = LIM_W + K_W;
    localparam int BPS_W    = SR_W + CH_W + 1;
    localparam int SHIFT    = 16 + ERROR_FRAC_BITS;
    localparam int DVS_W    = BPS_W + SHIFT;
    localparam int PROD_W   = MAG_W + DT_W;
    localparam int PL_W     = 32;
    localparam int PH_W     = PROD_W - PL_W;
    localparam int DVD_W    = PROD_W + PPB_W;
    localparam int CNT_W    = $clog2(DVD_W);
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [PPB_W-1:0] PPB_SCALE = PPB_W'(1000000000);
    localparam logic [K_W-1:0]   PPM_TO_PPB = K_W'(1000);

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAU         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP     = 3'd7;

    localparam logic [SR_W-1:0]      RST_SAMPLE_RATE = SR_W'(48000);
    localparam logic [CH_W-1:0]      RST_CHANNELS    = CH_W'(2);
    localparam logic [FILL_BITS-1:0] RST_TARGET      = FILL_BITS'(19200);
    localparam logic [GAIN_W-1:0]    RST_GAIN        = GAIN_W'(1311);
    localparam logic [TAU_W-1:0]     RST_TAU         = TAU_W'(8000);
    localparam logic [LIM_W-1:0]     RST_LIMIT       = LIM_W'(1000);
    localparam logic [15:0]          RST_WARMUP      = 16'd3000;
    localparam logic [15:0]          RST_MAX_GAP     = 16'd1000;

    typedef struct packed {
        logic                 mode;
        logic [FILL_BITS-1:0] fill_bytes;
        logic [TIME_BITS-1:0] time_ms;
    } t_in;

    typedef struct packed {
        logic signed [RATIO_W-1:0] ratio_ppb;
        logic                      locked;
    } t_out;

    typedef struct packed {
        logic latch;
        logic tgt;
        logic loop_rst;
        logic seed;
        logic advance;
        logic abs_diff;
        logic fmul;
        logic div_start;
        logic div_steer;
        logic fupd;
        logic sabs;
        logic smul1;
        logic smul2;
        logic smul3;
        logic sadd;
        logic supd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic started;
        logic stale;
        logic gap;
        logic warm_ok;
        logic div_done;
    } t_sts;

endpackage

// ----- rtl/cdrc_div.sv -----
// ============================================================================
// cdrc_div
// Restoring divider, one quotient bit per cycle, with half-up round flag.
// ============================================================================
module cdrc_div
    import cdrc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DVD_W-1:0] o_quo,
    output logic             o_rnd,
    output logic             o_done
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   rs;
    logic [DVS_W:0]   sub;
    logic             ge;

    always_comb begin
        rs  = {r_rem, r_quo[DVD_W-1]};
        sub = rs - {1'b0, r_dvs};
        ge  = rs >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNT_W'(DVD_W - 1);
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_quo <= {r_quo[DVD_W-2:0], ge};
            r_rem <= ge ? sub[DVS_W-1:0] : rs[DVS_W-1:0];
        end
    end

    assign o_quo  = r_quo;
    assign o_rnd  = {r_rem, 1'b0} >= {1'b0, r_dvs};
    assign o_done = r_done;

endmodule

// ----- rtl/cdrc_dpath.sv -----
// ============================================================================
// cdrc_dpath
// Loop state, configuration registers, filter and steering arithmetic.
// ============================================================================
module cdrc_dpath
    import cdrc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_in                  i_in_data,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output t_out                 o_out_data
);

    logic [SR_W-1:0]      r_sample_rate;
    logic [CH_W-1:0]      r_channels;
    logic [FILL_BITS-1:0] r_target;
    logic [GAIN_W-1:0]    r_gain;
    logic [TAU_W-1:0]     r_tau;
    logic [LIM_W-1:0]     r_limit;
    logic [15:0]          r_warmup;
    logic [15:0]          r_max_gap;

    logic                    r_started;
    logic signed [FE_W-1:0]  r_filt;
    logic signed [RATIO_W-1:0] r_ratio;
    logic [TIME_BITS-1:0]    r_last;
    logic [TIME_BITS-1:0]    r_seed;
    logic [FILL_BITS-1:0]    r_applied;

    t_in                     r_in;
    logic signed [FE_W-1:0]  r_err;
    logic signed [MAG_W-1:0] r_diff;
    logic [DT_W-1:0]         r_dt;
    logic [MAG_W-1:0]        r_mag;
    logic                    r_neg;
    logic [PROD_W-1:0]       r_prod;
    logic [BPS_W-1:0]        r_bps;
    logic [PH_W+PPB_W-1:0]   r_ph;
    logic [PL_W+PPB_W-1:0]   r_pl;
    logic [DVD_W-1:0]        r_num;
    t_out                    r_out;

    logic                    tgt_chg;
    logic [FILL_BITS-1:0]    applied_nx;
    logic signed [FILL_BITS:0] tdelta;
    logic signed [FILL_BITS:0] edelta;
    logic [TIME_BITS-1:0]    dt_full;
    logic [BPS_W-1:0]        bps;
    logic [DVD_W-1:0]        dividend;
    logic [DVS_W-1:0]        divisor;
    logic [TAU_W:0]          tau_dt;
    logic [DVD_W-1:0]        d_quo;
    logic                    d_rnd;
    logic                    d_done;
    logic [DVD_W-1:0]        q_r;
    logic [CAP_W-1:0]        cap;
    logic [CAP_W-1:0]        q_cap;

    always_comb begin
        tgt_chg    = (r_target != '0) && (r_target != r_applied);
        applied_nx = tgt_chg ? r_target : r_applied;
        tdelta     = $signed({1'b0, r_applied}) - $signed({1'b0, r_target});
        edelta     = $signed({1'b0, r_in.fill_bytes}) - $signed({1'b0, applied_nx});
        dt_full    = r_in.time_ms - r_last;
        bps        = {(SR_W+CH_W)'(r_sample_rate) * (SR_W+CH_W)'(r_channels), 1'b0};
        if (bps == '0) begin
            bps = BPS_W'(1);
        end
        tau_dt     = {1'b0, r_tau} + {1'b0, r_dt};
        dividend   = i_cmd.div_steer ? r_num : {{(DVD_W-PROD_W){1'b0}}, r_prod};
        divisor    = i_cmd.div_steer ? {r_bps, {SHIFT{1'b0}}}
                                     : {{(DVS_W-TAU_W-1){1'b0}}, tau_dt};
        q_r        = d_quo + {{(DVD_W-1){1'b0}}, d_rnd};
        cap        = CAP_W'(r_limit) * CAP_W'(PPM_TO_PPB);
        q_cap      = (q_r > {{(DVD_W-CAP_W){1'b0}}, cap}) ? cap : q_r[CAP_W-1:0];
    end

    cdrc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_quo      (d_quo),
        .o_rnd      (d_rnd),
        .o_done     (d_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= RST_SAMPLE_RATE;
            r_channels    <= RST_CHANNELS;
            r_target      <= RST_TARGET;
            r_gain        <= RST_GAIN;
            r_tau         <= RST_TAU;
            r_limit       <= RST_LIMIT;
            r_warmup      <= RST_WARMUP;
            r_max_gap     <= RST_MAX_GAP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SAMPLE_RATE: r_sample_rate <= i_cfg_data[SR_W-1:0];
                REG_CHANNELS:    r_channels    <= i_cfg_data[CH_W-1:0];
                REG_TARGET:      r_target      <= i_cfg_data[FILL_BITS-1:0];
                REG_GAIN:        r_gain        <= i_cfg_data[GAIN_W-1:0];
                REG_TAU:         r_tau         <= i_cfg_data[TAU_W-1:0];
                REG_LIMIT:       r_limit       <= i_cfg_data[LIM_W-1:0];
                REG_WARMUP:      r_warmup      <= i_cfg_data[15:0];
                REG_MAX_GAP:     r_max_gap     <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_filt    <= '0;
            r_ratio   <= '0;
            r_last    <= '0;
            r_seed    <= '0;
            r_applied <= RST_TARGET;
        end else begin
            if (i_cmd.tgt) begin
                if (tgt_chg) begin
                    r_filt <= r_filt + {{(FE_W-FILL_BITS-1-ERROR_FRAC_BITS){tdelta[FILL_BITS]}},
                                        tdelta, {ERROR_FRAC_BITS{1'b0}}};
                end
                r_applied <= applied_nx;
            end
            if (i_cmd.seed) begin
                r_filt    <= r_err;
                r_last    <= r_in.time_ms;
                r_seed    <= r_in.time_ms;
                r_started <= 1'b1;
            end
            if (i_cmd.advance) begin
                r_last <= r_in.time_ms;
            end
            if (i_cmd.fupd) begin
                r_filt <= r_neg ? r_filt - $signed(q_r[FE_W-1:0])
                                : r_filt + $signed(q_r[FE_W-1:0]);
            end
            if (i_cmd.supd) begin
                r_ratio <= r_neg ? -$signed({1'b0, q_cap}) : $signed({1'b0, q_cap});
            end
            if (i_cmd.loop_rst) begin
                r_started <= 1'b0;
                r_filt    <= '0;
                r_ratio   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_in <= i_in_data;
        end
        if (i_cmd.tgt) begin
            r_err <= {{(FE_W-FILL_BITS-1-ERROR_FRAC_BITS){edelta[FILL_BITS]}},
                      edelta, {ERROR_FRAC_BITS{1'b0}}};
        end
        if (i_cmd.advance) begin
            r_dt   <= dt_full[DT_W-1:0];
            r_diff <= {r_err[FE_W-1], r_err} - {r_filt[FE_W-1], r_filt};
        end
        if (i_cmd.abs_diff) begin
            r_neg <= r_diff[MAG_W-1];
            r_mag <= r_diff[MAG_W-1] ? -r_diff : r_diff;
        end
        if (i_cmd.sabs) begin
            r_neg <= r_filt[FE_W-1];
            r_mag <= r_filt[FE_W-1] ? -{r_filt[FE_W-1], r_filt} : {1'b0, r_filt};
        end
        if (i_cmd.fmul) begin
            r_prod <= {{DT_W{1'b0}}, r_mag} * {{MAG_W{1'b0}}, r_dt};
        end
        if (i_cmd.smul1) begin
            r_prod <= {{GAIN_W{1'b0}}, r_mag} * {{MAG_W{1'b0}}, r_gain};
            r_bps  <= bps;
        end
        if (i_cmd.smul2) begin
            r_ph <= {{PPB_W{1'b0}}, r_prod[PROD_W-1:PL_W]} * {{PH_W{1'b0}}, PPB_SCALE};
        end
        if (i_cmd.smul3) begin
            r_pl <= {{PPB_W{1'b0}}, r_prod[PL_W-1:0]} * {{PL_W{1'b0}}, PPB_SCALE};
        end
        if (i_cmd.sadd) begin
            r_num <= {r_ph, {PL_W{1'b0}}} + {{(DVD_W-PL_W-PPB_W){1'b0}}, r_pl};
        end
        if (i_cmd.out_load) begin
            r_out.ratio_ppb <= r_ratio;
            r_out.locked    <= r_started && ((r_last - r_seed) >= {{(TIME_BITS-16){1'b0}},
                                                                   r_warmup});
        end
    end

    always_comb begin
        o_sts.mode     = r_in.mode;
        o_sts.started  = r_started;
        o_sts.stale    = r_in.time_ms <= r_last;
        o_sts.gap      = dt_full > {{(TIME_BITS-16){1'b0}}, r_max_gap};
        o_sts.warm_ok  = (r_in.time_ms - r_seed) >= {{(TIME_BITS-16){1'b0}}, r_warmup};
        o_sts.div_done = d_done;
    end

    assign o_out_data = r_out;

endmodule

// ----- rtl/cdrc_ctrl.sv -----
// ============================================================================
// cdrc_ctrl
// Sequencer for one measurement: loop reset or target shift, seed, filter, steer, output.
// ============================================================================
module cdrc_ctrl
    import cdrc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TGT   = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_ABS   = 4'd3;
    localparam logic [3:0] S_FMUL  = 4'd4;
    localparam logic [3:0] S_FDIV  = 4'd5;
    localparam logic [3:0] S_FWAIT = 4'd6;
    localparam logic [3:0] S_WARM  = 4'd7;
    localparam logic [3:0] S_SABS  = 4'd8;
    localparam logic [3:0] S_SMUL1 = 4'd9;
    localparam logic [3:0] S_SMUL2 = 4'd10;
    localparam logic [3:0] S_SMUL3 = 4'd11;
    localparam logic [3:0] S_SADD  = 4'd12;
    localparam logic [3:0] S_SDIV  = 4'd13;
    localparam logic [3:0] S_SWAIT = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_TGT;
                end
            end
            S_TGT: begin
                if (i_sts.mode) begin
                    o_cmd.loop_rst = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.tgt = 1'b1;
                    n_state   = S_DEC;
                end
            end
            S_DEC: begin
                if (!i_sts.started) begin
                    o_cmd.seed = 1'b1;
                    n_state    = S_DONE;
                end else if (i_sts.stale) begin
                    n_state = S_DONE;
                end else if (i_sts.gap) begin
                    o_cmd.advance  = 1'b1;
                    o_cmd.loop_rst = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_ABS;
                end
            end
            S_ABS: begin
                o_cmd.abs_diff = 1'b1;
                n_state        = S_FMUL;
            end
            S_FMUL: begin
                o_cmd.fmul = 1'b1;
                n_state    = S_FDIV;
            end
            S_FDIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_FWAIT;
            end
            S_FWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.fupd = 1'b1;
                    n_state    = S_WARM;
                end
            end
            S_WARM: begin
                n_state = i_sts.warm_ok ? S_SABS : S_DONE;
            end
            S_SABS: begin
                o_cmd.sabs = 1'b1;
                n_state    = S_SMUL1;
            end
            S_SMUL1: begin
                o_cmd.smul1 = 1'b1;
                n_state     = S_SMUL2;
            end
            S_SMUL2: begin
                o_cmd.smul2 = 1'b1;
                n_state     = S_SMUL3;
            end
            S_SMUL3: begin
                o_cmd.smul3 = 1'b1;
                n_state     = S_SADD;
            end
            S_SADD: begin
                o_cmd.sadd = 1'b1;
                n_state    = S_SDIV;
            end
            S_SDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_steer = 1'b1;
                n_state         = S_SWAIT;
            end
            S_SWAIT: begin
                o_cmd.div_steer = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.supd = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/clock_drift_ratio_controller.sv -----
// ============================================================================
// clock_drift_ratio_controller
// A reset beat goes from S_TGT to S_DONE; seed, stale and gap beats end at S_DEC;
// a filtered beat in warm-up ends after the filter division, and a steered beat
// also runs the steering division. Each division runs one quotient bit per
// cycle over 95 bits in a shared divider. One beat in flight; the next beat
// is taken in the cycle after the result loads, also while the result waits.
// Synchronous active-low reset loads register defaults and an unstarted loop.
// ============================================================================
module clock_drift_ratio_controller
    import cdrc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data
);

    t_cmd cmd;
    t_sts sts;

    cdrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cdrc_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule
